// ===== rtl/btpc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the barometer compensation block.
`default_nettype none
package btpc_pkg;

  localparam int RAW_W       = 20;
  localparam int FINE_W      = 26;
  localparam int DIV_STEPS   = 64;
  localparam int FINE_OFFSET = 128000;
  localparam int PRESS_BASE  = 1048576;
  localparam int PRESS_SCALE = 3125;
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 2;

  typedef enum logic [1:0] {
    REG_TEMP_CAL,
    REG_PRESS_LOW,
    REG_PRESS_HIGH,
    REG_PRESS_NINTH
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [FINE_W-1:0] fine;
    logic signed [15:0]       tc;
    logic        [RAW_W-1:0]  rp;
  } mid_t;

  typedef struct packed {
    logic signed [15:0] tc;
    logic        [31:0] pq;
    logic               err;
  } out_t;

  typedef struct packed {
    logic signed [15:0] tc;
    logic               neg;
    logic               zero;
  } side_t;

  // partial products of a 64x64 multiply kept modulo 2^64
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  function automatic pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = 64'(a[31:0]) * 64'(b[31:0]);
    r.lh = a[31:0] * b[63:32];
    r.hl = a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'b0};
  endfunction

  function automatic logic [63:0] sx16(input logic signed [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/btpc_queue.sv =====
// Small register FIFO used between the front and back and at the result side.
`default_nettype none
module btpc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = btpc_pkg::MID_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/btpc_front.sv =====
// Front pipeline: accepts raw samples, computes fine and centi-degree temperature.
`default_nettype none
module btpc_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire btpc_pkg::cal_t         cal,
  input  wire logic                   push,
  input  wire logic [19:0]            raw_temperature,
  input  wire logic [19:0]            raw_pressure,
  output logic                        full,
  input  wire logic                   mid_full,
  output logic                        mid_push,
  output btpc_pkg::mid_t              mid_data
);
  logic [5:0]         v;
  logic               en;
  logic [19:0]        rt0;
  logic [19:0]        rp0, rp1, rp2, rp3, rp4, rp5;
  logic signed [17:0] a1;
  logic signed [16:0] b1;
  logic signed [33:0] m2;
  logic signed [33:0] bb2;
  logic signed [22:0] x3, x4;
  logic signed [21:0] bs3;
  logic signed [37:0] y4;
  logic signed [btpc_pkg::FINE_W-1:0] fine5;
  logic signed [28:0] t5;
  logic signed [20:0] ts;
  logic signed [15:0] tc;

  // stall only when the last stage holds a request the queue cannot take
  assign en       = !(v[5] && mid_full);
  assign full     = !en;
  assign mid_push = v[5] && !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt0   <= raw_temperature;
      rp0   <= raw_pressure;
      a1    <= $signed({1'b0, rt0[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      b1    <= $signed({1'b0, rt0[19:4]}) - $signed({1'b0, cal.t1});
      rp1   <= rp0;
      m2    <= a1 * cal.t2;
      bb2   <= b1 * b1;
      rp2   <= rp1;
      x3    <= 23'(m2 >>> 11);
      bs3   <= 22'(bb2 >>> 12);
      rp3   <= rp2;
      x4    <= x3;
      y4    <= bs3 * cal.t3;
      rp4   <= rp3;
      fine5 <= btpc_pkg::FINE_W'(x4) + btpc_pkg::FINE_W'(y4 >>> 14);
      rp5   <= rp4;
    end
  end

  always_comb begin
    t5 = 29'(fine5) * 29'sd5 + 29'sd128;
    ts = 21'(t5 >>> 8);
    if (ts > 21'sd32767) begin
      tc = 16'sh7FFF;
    end else if (ts < -21'sd32768) begin
      tc = 16'sh8000;
    end else begin
      tc = 16'(ts);
    end
    mid_data.fine = fine5;
    mid_data.tc   = tc;
    mid_data.rp   = rp5;
  end
endmodule
`default_nettype wire

// ===== rtl/btpc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
`default_nettype none
module btpc_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [63:0]     dividend,
  input  wire logic [30:0]     divisor,
  input  wire btpc_pkg::side_t in_side,
  output logic                 out_valid,
  output logic [63:0]          quotient,
  output btpc_pkg::side_t      out_side
);
  localparam int STEPS = btpc_pkg::DIV_STEPS;

  logic            v   [0:STEPS];
  logic [63:0]     dq  [0:STEPS];
  logic [30:0]     rem [0:STEPS];
  logic [30:0]     mb  [0:STEPS];
  btpc_pkg::side_t sd  [0:STEPS];

  assign v[0]   = in_valid;
  assign dq[0]  = dividend;
  assign rem[0] = '0;
  assign mb[0]  = divisor;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [31:0] trial;
    logic        ge;

    assign trial = {rem[i], dq[i][63]};
    assign ge    = (trial >= {1'b0, mb[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? 31'(trial - {1'b0, mb[i]}) : trial[30:0];
        dq[i+1]  <= {dq[i][62:0], ge};
        mb[i+1]  <= mb[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = v[STEPS];
  assign quotient  = dq[STEPS];
  assign out_side  = sd[STEPS];
endmodule
`default_nettype wire

// ===== rtl/btpc_back.sv =====
// Back pipeline: pressure coefficients, divide, correction terms and clamp.
`default_nettype none
module btpc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire btpc_pkg::cal_t cal,
  input  wire logic           mid_empty,
  input  wire btpc_pkg::mid_t mid_data,
  output logic                mid_pop,
  input  wire logic           out_full,
  output logic                out_push,
  output btpc_pkg::out_t      out_data
);
  logic        en;
  logic [8:0]  vb;
  logic [5:0]  vp;

  // B stages
  logic signed [26:0] x0;
  logic [19:0]        rp0, rp1, rp2, rp3, rp4;
  logic signed [15:0] tc0, tc1, tc2, tc3, tc4, tc5, tc6, tc7;
  btpc_pkg::pp_t      ppxx1, pp6_3, pp3_3, pp1_5, ppk_6;
  logic signed [42:0] xp5_1, xp5_2, xp5_3;
  logic signed [42:0] xp2_1, xp2_2, xp2_3;
  logic [63:0]        xx2, y4, v4, pn5, n7, ma8;
  logic [63:0]        prod1;
  logic signed [30:0] d6, d7;
  logic [30:0]        mb8;
  btpc_pkg::side_t    side8;

  // divider
  logic               dv;
  logic [63:0]        dq;
  btpc_pkg::side_t    dside;

  // P stages
  logic [63:0]        p0, p1, p2, p3, p4;
  logic [63:0]        a1, a2, m2, y2, y3, y4p, x4;
  btpc_pkg::pp_t      pp9_1, pp8_1, ppm_3;
  btpc_pkg::side_t    sd0, sd1, sd2, sd3, sd4, sd5;
  logic [63:0]        s5;
  logic [20:0]        pdiff;

  assign en       = !(vp[5] && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = vp[5] && !out_full;
  assign prod1    = btpc_pkg::mul_sum(pp1_5);
  assign pdiff    = 21'(btpc_pkg::PRESS_BASE) - {1'b0, rp4};

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
      vp <= '0;
    end else if (en) begin
      vb <= {vb[7:0], !mid_empty};
      vp <= {vp[4:0], dv};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0    <= 27'(mid_data.fine) - 27'(btpc_pkg::FINE_OFFSET);
      rp0   <= mid_data.rp;
      tc0   <= mid_data.tc;
      ppxx1 <= btpc_pkg::mul_parts(64'(x0), 64'(x0));
      xp5_1 <= x0 * cal.p5;
      xp2_1 <= x0 * cal.p2;
      rp1   <= rp0;
      tc1   <= tc0;
      xx2   <= btpc_pkg::mul_sum(ppxx1);
      xp5_2 <= xp5_1;
      xp2_2 <= xp2_1;
      rp2   <= rp1;
      tc2   <= tc1;
      pp6_3 <= btpc_pkg::mul_parts(xx2, btpc_pkg::sx16(cal.p6));
      pp3_3 <= btpc_pkg::mul_parts(xx2, btpc_pkg::sx16(cal.p3));
      xp5_3 <= xp5_2;
      xp2_3 <= xp2_2;
      rp3   <= rp2;
      tc3   <= tc2;
      y4    <= btpc_pkg::mul_sum(pp6_3) + (64'(xp5_3) << 17)
               + (btpc_pkg::sx16(cal.p4) << 35);
      v4    <= 64'($signed(btpc_pkg::mul_sum(pp3_3)) >>> 8) + (64'(xp2_3) << 12);
      rp4   <= rp3;
      tc4   <= tc3;
      pp1_5 <= btpc_pkg::mul_parts(v4 + (64'd1 << 47), {48'b0, cal.p1});
      pn5   <= {12'b0, pdiff, 31'b0} - y4;
      tc5   <= tc4;
      d6    <= $signed(prod1[63:33]);
      ppk_6 <= btpc_pkg::mul_parts(pn5, 64'(btpc_pkg::PRESS_SCALE));
      tc6   <= tc5;
      d7    <= d6;
      n7    <= btpc_pkg::mul_sum(ppk_6);
      tc7   <= tc6;
      ma8   <= n7[63] ? 64'd0 - n7 : n7;
      mb8   <= d7[30] ? 31'd0 - d7 : d7;
      side8.tc   <= tc7;
      side8.neg  <= n7[63] ^ d7[30];
      side8.zero <= (d7 == '0);
    end
  end

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb[8]),
    .dividend  (ma8),
    .divisor   (mb8),
    .in_side   (side8),
    .out_valid (dv),
    .quotient  (dq),
    .out_side  (dside)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p0    <= dside.neg ? 64'd0 - dq : dq;
      sd0   <= dside;
      a1    <= 64'($signed(p0) >>> 13);
      pp9_1 <= btpc_pkg::mul_parts(64'($signed(p0) >>> 13), btpc_pkg::sx16(cal.p9));
      pp8_1 <= btpc_pkg::mul_parts(p0, btpc_pkg::sx16(cal.p8));
      p1    <= p0;
      sd1   <= sd0;
      m2    <= btpc_pkg::mul_sum(pp9_1);
      y2    <= 64'($signed(btpc_pkg::mul_sum(pp8_1)) >>> 19);
      a2    <= a1;
      p2    <= p1;
      sd2   <= sd1;
      ppm_3 <= btpc_pkg::mul_parts(m2, a2);
      y3    <= y2;
      p3    <= p2;
      sd3   <= sd2;
      x4    <= 64'($signed(btpc_pkg::mul_sum(ppm_3)) >>> 25);
      y4p   <= y3;
      p4    <= p3;
      sd4   <= sd3;
      s5    <= 64'($signed(p4 + x4 + y4p) >>> 8) + (btpc_pkg::sx16(cal.p7) << 4);
      sd5   <= sd4;
    end
  end

  // clamp to the unsigned 32-bit range; a zero divisor forces zero
  always_comb begin
    out_data.tc  = sd5.tc;
    out_data.err = sd5.zero;
    if (sd5.zero || s5[63]) begin
      out_data.pq = '0;
    end else if (|s5[62:32]) begin
      out_data.pq = '1;
    end else begin
      out_data.pq = s5[31:0];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/barometer_temp_pressure_compensate.sv =====
// Throughput: one sample pair per cycle while neither pipeline stalls; the divider is 64 pipelined stages.
// Front and back stall separately; the back stalls only when the result queue is full.
// Reset (rst, synchronous) empties both queues and pipelines and zeroes calibration.
// After reset P1 is zero, so every result carries pressure_error until calibrated.
`default_nettype none
module barometer_temp_pressure_compensate #(
  parameter int MID_DEPTH = btpc_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = btpc_pkg::OUT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [19:0]        raw_temperature,
  input  wire logic [19:0]        raw_pressure,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      temperature_centi,
  output logic [31:0]             pressure_q24_8,
  output logic                    pressure_error,
  input  wire logic               write_enable,
  input  wire logic [1:0]         write_index,
  input  wire logic [63:0]        write_data
);
  logic [47:0]           temp_cal_words;
  logic [63:0]           press_cal_low_words;
  logic [63:0]           press_cal_high_words;
  logic [15:0]           press_cal_ninth;
  btpc_pkg::cal_t        cal;
  logic                  mid_full, mid_push, mid_empty, mid_pop;
  btpc_pkg::mid_t        mid_in, mid_out;
  logic                  out_full, out_push;
  btpc_pkg::out_t        out_in, out_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal_words       <= '0;
      press_cal_low_words  <= '0;
      press_cal_high_words <= '0;
      press_cal_ninth      <= '0;
    end else if (write_enable) begin
      case (write_index)
        btpc_pkg::REG_TEMP_CAL:    temp_cal_words       <= write_data[47:0];
        btpc_pkg::REG_PRESS_LOW:   press_cal_low_words  <= write_data;
        btpc_pkg::REG_PRESS_HIGH:  press_cal_high_words <= write_data;
        btpc_pkg::REG_PRESS_NINTH: press_cal_ninth      <= write_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal_words[15:0];
    cal.t2 = temp_cal_words[31:16];
    cal.t3 = temp_cal_words[47:32];
    cal.p1 = press_cal_low_words[15:0];
    cal.p2 = press_cal_low_words[31:16];
    cal.p3 = press_cal_low_words[47:32];
    cal.p4 = press_cal_low_words[63:48];
    cal.p5 = press_cal_high_words[15:0];
    cal.p6 = press_cal_high_words[31:16];
    cal.p7 = press_cal_high_words[47:32];
    cal.p8 = press_cal_high_words[63:48];
    cal.p9 = press_cal_ninth;
  end

  btpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .push            (push),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .full            (full),
    .mid_full        (mid_full),
    .mid_push        (mid_push),
    .mid_data        (mid_in)
  );

  btpc_queue #(
    .W     ($bits(btpc_pkg::mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  btpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .mid_empty (mid_empty),
    .mid_data  (mid_out),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_in)
  );

  btpc_queue #(
    .W     ($bits(btpc_pkg::out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_out),
    .empty (empty)
  );

  assign temperature_centi = out_out.tc;
  assign pressure_q24_8    = out_out.pq;
  assign pressure_error    = out_out.err;
endmodule
`default_nettype wire
